@@ src/sae_pkg.sv @@
// Shared types, constants and AQI breakpoint tables for the sensor alarm unit.
package sae_pkg;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 20;

  localparam int PM_W    = 14;
  localparam int TEMP_W  = 11;
  localparam int AQI_W   = 13;
  localparam int HOLD_W  = 20;
  localparam int ACT_W   = 5;
  localparam int TIME_W  = 32;
  localparam int DEV_W   = 4;

  localparam int DIFF_W  = 11;  // P - Clo, at most 1499
  localparam int SPAN_W  = 10;  // 10 * (Ihi - Ilo), at most 1000
  localparam int PROD_W  = DIFF_W + SPAN_W;
  localparam int QUOT_W  = 10;  // quotient never exceeds 1000
  localparam int SEG_N   = 7;
  localparam int SEG_W   = 3;

  localparam logic [AQI_W-1:0] AQI_MAX = 13'd5000;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_TEMP_LIMIT = 3'd0,
    CFG_PM25_LIMIT = 3'd1,
    CFG_AQI_LIMIT  = 3'd2,
    CFG_HOLDOFF    = 3'd3,
    CFG_ACTIVE     = 3'd4
  } cfg_idx_t;

  typedef enum logic {
    OPC_SCAN     = 1'b0,
    OPC_PERIODIC = 1'b1
  } opcode_t;

  // Lower breakpoint of PM2.5 segment, tenths
  function automatic logic [PM_W-1:0] seg_clo(input logic [SEG_W-1:0] k);
    logic [PM_W-1:0] v;
    unique case (k)
      3'd0:    v = 14'd0;
      3'd1:    v = 14'd121;
      3'd2:    v = 14'd355;
      3'd3:    v = 14'd555;
      3'd4:    v = 14'd1505;
      3'd5:    v = 14'd2505;
      3'd6:    v = 14'd3505;
      default: v = 14'd0;
    endcase
    return v;
  endfunction

  // Upper breakpoint of PM2.5 segment, tenths
  function automatic logic [PM_W-1:0] seg_chi(input logic [SEG_W-1:0] k);
    logic [PM_W-1:0] v;
    unique case (k)
      3'd0:    v = 14'd120;
      3'd1:    v = 14'd354;
      3'd2:    v = 14'd554;
      3'd3:    v = 14'd1504;
      3'd4:    v = 14'd2504;
      3'd5:    v = 14'd3504;
      3'd6:    v = 14'd5004;
      default: v = 14'd0;
    endcase
    return v;
  endfunction

  // 10 * lower index of segment
  function automatic logic [AQI_W-1:0] seg_base(input logic [SEG_W-1:0] k);
    logic [AQI_W-1:0] v;
    unique case (k)
      3'd0:    v = 13'd0;
      3'd1:    v = 13'd510;
      3'd2:    v = 13'd1010;
      3'd3:    v = 13'd1510;
      3'd4:    v = 13'd2010;
      3'd5:    v = 13'd3010;
      3'd6:    v = 13'd4010;
      default: v = 13'd0;
    endcase
    return v;
  endfunction

  // 10 * (upper index - lower index) of segment
  function automatic logic [SPAN_W-1:0] seg_span(input logic [SEG_W-1:0] k);
    logic [SPAN_W-1:0] v;
    unique case (k)
      3'd0:    v = 10'd500;
      3'd1:    v = 10'd490;
      3'd2:    v = 10'd490;
      3'd3:    v = 10'd490;
      3'd4:    v = 10'd990;
      3'd5:    v = 10'd990;
      3'd6:    v = 10'd990;
      default: v = 10'd0;
    endcase
    return v;
  endfunction

endpackage

@@ src/sae_ram.sv @@
// Generic single-port-write, single-port-read RAM with registered read data.
module sae_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                                  clk,
  input  logic                                  we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                      wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                      rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ src/sensor_alarm_with_holdoff_unit.sv @@
// Top level of the sensor alarm unit: AQI computation, threshold checks, per-device holdoff.
//
// Each s_ transaction carries one sample of one device; exactly one m_ transaction
// comes back per sample, in order. The PM2.5 AQI (tenths, floored) is found by
// selecting the breakpoint segment, forming 10*(Ihi-Ilo)*(P-Clo) in one multiply,
// then dividing by the segment width on a restoring subtract/compare unit
// that retires one quotient bit per cycle. After acceptance an item passes through
// segment selection and RAM read, then the multiply and holdoff compare, then the
// divide steps, then a finish state that loads the result; s_tready is high again
// the cycle after that load, so a new item is taken only once the previous result
// has been loaded, which waits while m_tready holds an earlier result back.
// Per-device last-event times live in a small RAM of DEVICES
// words; a valid bit per entry, cleared by reset, makes unwritten entries read as
// zero, so there is no clearing pass after reset. Thresholds and holdoff are written
// through the cfg_ port and must only change while the unit is idle.
module sensor_alarm_with_holdoff_unit
  import sae_pkg::*;
#(
  parameter int DEVICES = 16
) (
  input  logic                  clk,
  input  logic                  rst,
  // configuration write port
  input  logic                  cfg_wen,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  // sample input
  input  logic                  s_tvalid,
  output logic                  s_tready,
  // [3:0] device_index, [4] device_on, [36:5] now_ms, [47:37] temperature_tenths,
  // [61:48] pm25_tenths, [63:62] zero
  input  logic [63:0]           s_tdata,
  // [0] opcode
  input  logic                  s_tuser,
  // result output
  output logic                  m_tvalid,
  input  logic                  m_tready,
  // [0] alarm_event, [1] temp_over, [2] pm25_over, [3] aqi_over, [4] held_off,
  // [17:5] aqi_tenths, [23:18] zero
  output logic [23:0]           m_tdata
);

  localparam int AW    = (DEVICES > 1) ? $clog2(DEVICES) : 1;
  localparam int DEV_X = 9;  // wide enough to hold DEVICES itself

  typedef enum logic [2:0] {
    S_IDLE,
    S_SEG,
    S_MUL,
    S_DIV,
    S_FIN
  } state_t;

  state_t state;

  // configuration registers
  logic signed [TEMP_W-1:0] temp_limit;
  logic [PM_W-1:0]          pm25_limit;
  logic [AQI_W-1:0]         aqi_limit;
  logic [HOLD_W-1:0]        holdoff;
  logic [ACT_W-1:0]         active_devices;

  // captured sample
  logic                     opc_r;
  logic [DEV_W-1:0]         dev_r;
  logic                     on_r;
  logic [TIME_W-1:0]        now_r;
  logic signed [TEMP_W-1:0] temp_r;
  logic [PM_W-1:0]          pm_r;

  // working registers
  logic [DIFF_W-1:0]        diff_r;
  logic [SPAN_W-1:0]        span_r;
  logic [DIFF_W-1:0]        den_r;
  logic [AQI_W-1:0]         base_r;
  logic                     t_over_r;
  logic                     p_over_r;
  logic                     active_r;
  logic                     hold_ok_r;
  logic [DIFF_W-1:0]        rem_r;
  logic [QUOT_W-1:0]        quot_r;
  logic [3:0]               cnt_r;

  logic [DEVICES-1:0]       stamp_valid;

  // segment select: lowest segment whose upper breakpoint covers P
  logic [SEG_W-1:0] seg_sel;
  logic             seg_hit;
  always_comb begin
    seg_sel = '0;
    seg_hit = 1'b0;
    for (int k = SEG_N - 1; k >= 0; k--) begin
      if (pm_r <= seg_chi(SEG_W'(k))) begin
        seg_sel = SEG_W'(k);
        seg_hit = 1'b1;
      end
    end
  end

  logic [PM_W-1:0]   pm_off;
  logic [PM_W-1:0]   seg_width;
  assign pm_off    = pm_r - seg_clo(seg_sel);
  assign seg_width = seg_chi(seg_sel) - seg_clo(seg_sel);

  // device address and activity
  logic [DEV_X-1:0] dev_ext;
  logic [AW-1:0]    dev_addr;
  logic             active_now;
  assign dev_ext    = {{(DEV_X - DEV_W){1'b0}}, dev_r};
  assign dev_addr   = dev_ext[AW-1:0];
  assign active_now = on_r && (dev_ext < DEV_X'(DEVICES))
                      && ({1'b0, dev_r} < active_devices);

  // last-event time store
  logic                ram_we;
  logic [TIME_W-1:0]   ram_rdata;
  logic [TIME_W-1:0]   last_time;
  logic [TIME_W-1:0]   elapsed;

  sae_ram #(
    .WIDTH (TIME_W),
    .DEPTH (DEVICES)
  ) u_stamp_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (dev_addr),
    .wdata (now_r),
    .raddr (dev_addr),
    .rdata (ram_rdata)
  );

  assign last_time = stamp_valid[dev_addr] ? ram_rdata : '0;
  assign elapsed   = now_r - last_time;

  // multiply: numerator of the interpolation
  logic [PROD_W-1:0] prod;
  assign prod = PROD_W'(span_r) * PROD_W'(diff_r);

  // divide step
  logic [DIFF_W:0] div_trial;
  logic            div_ge;
  logic [DIFF_W:0] div_sub;
  assign div_trial = {rem_r, quot_r[QUOT_W-1]};
  assign div_ge    = div_trial >= {1'b0, den_r};
  assign div_sub   = div_trial - {1'b0, den_r};

  // final decision
  logic [AQI_W-1:0] aqi_val;
  logic             a_over;
  logic             any_over;
  logic             event_fire;
  logic             held;
  logic             m_load;
  assign aqi_val    = base_r + AQI_W'(quot_r);
  assign a_over     = aqi_val >= aqi_limit;
  assign any_over   = t_over_r || p_over_r || a_over;
  assign held       = active_r && (opc_r == OPC_SCAN) && !hold_ok_r;
  assign event_fire = active_r && any_over && ((opc_r == OPC_PERIODIC) || hold_ok_r);
  assign m_load     = (state == S_FIN) && (!m_tvalid || m_tready);
  assign ram_we     = m_load && event_fire;

  assign s_tready = (state == S_IDLE);

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      temp_limit     <= 11'sd320;
      pm25_limit     <= 14'd350;
      aqi_limit      <= 13'd1000;
      holdoff        <= 20'd3000;
      active_devices <= 5'd3;
    end else if (cfg_wen) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_TEMP_LIMIT: temp_limit     <= cfg_data[TEMP_W-1:0];
        CFG_PM25_LIMIT: pm25_limit     <= cfg_data[PM_W-1:0];
        CFG_AQI_LIMIT:  aqi_limit      <= cfg_data[AQI_W-1:0];
        CFG_HOLDOFF:    holdoff        <= cfg_data[HOLD_W-1:0];
        CFG_ACTIVE:     active_devices <= cfg_data[ACT_W-1:0];
        default:        ;
      endcase
    end
  end

  // sequencer and registered outputs
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      m_tvalid    <= 1'b0;
      stamp_valid <= '0;
    end else begin
      if (m_load) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      if (ram_we) begin
        stamp_valid[dev_addr] <= 1'b1;
      end
      unique case (state)
        S_IDLE: if (s_tvalid) begin
          state <= S_SEG;
        end
        S_SEG: begin
          state <= S_MUL;
        end
        S_MUL: begin
          state <= S_DIV;
        end
        S_DIV: if (cnt_r == 4'(QUOT_W - 1)) begin
          state <= S_FIN;
        end
        S_FIN: if (m_load) begin
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    unique case (state)
      S_IDLE: if (s_tvalid) begin
        opc_r  <= s_tuser;
        dev_r  <= s_tdata[3:0];
        on_r   <= s_tdata[4];
        now_r  <= s_tdata[36:5];
        temp_r <= s_tdata[47:37];
        pm_r   <= s_tdata[61:48];
      end
      S_SEG: begin
        // above the top breakpoint: AQI pinned to 500.0, divide yields zero
        diff_r   <= seg_hit ? pm_off[DIFF_W-1:0] : '0;
        span_r   <= seg_hit ? seg_span(seg_sel) : '0;
        den_r    <= seg_hit ? seg_width[DIFF_W-1:0] : DIFF_W'(1);
        base_r   <= seg_hit ? seg_base(seg_sel) : AQI_MAX;
        t_over_r <= temp_r >= temp_limit;
        p_over_r <= pm_r >= pm25_limit;
        active_r <= active_now;
      end
      S_MUL: begin
        // quotient fits ten bits, so the top part already sits below the divisor
        rem_r     <= prod[PROD_W-1:QUOT_W];
        quot_r    <= prod[QUOT_W-1:0];
        cnt_r     <= '0;
        hold_ok_r <= elapsed >= TIME_W'(holdoff);
      end
      S_DIV: begin
        rem_r  <= div_ge ? div_sub[DIFF_W-1:0] : div_trial[DIFF_W-1:0];
        quot_r <= {quot_r[QUOT_W-2:0], div_ge};
        cnt_r  <= cnt_r + 4'd1;
      end
      S_FIN: if (m_load) begin
        m_tdata <= {6'd0, aqi_val, held, a_over, p_over_r, t_over_r, event_fire};
      end
      default: ;
    endcase
  end

  // restoring divide keeps the partial remainder below the divisor
  a_rem_bound: assert property (@(posedge clk) disable iff (rst)
    (state == S_DIV) |-> (rem_r < den_r))
    else $error("partial remainder not below divisor");

  a_div_count: assert property (@(posedge clk) disable iff (rst)
    (state == S_DIV) |-> (cnt_r < 4'(QUOT_W)))
    else $error("divide step count overrun");

  a_write_active: assert property (@(posedge clk) disable iff (rst)
    ram_we |-> (active_r && (state == S_FIN)))
    else $error("time stamp written for inactive device");

  a_event_xor_held: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> !(m_tdata[0] && m_tdata[4]))
    else $error("event raised while held off");

  a_aqi_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata[17:5] <= AQI_MAX))
    else $error("AQI out of range");

endmodule

@@ tb/sv/sensor_alarm_with_holdoff_unit_tb.sv @@
// Self-checking testbench for the sensor alarm unit: directed table, then random samples.
module sensor_alarm_with_holdoff_unit_tb
  import sae_pkg::*;
();

  localparam int CYCLE_LIMIT = 1_000_000;
  localparam int SAMPLES_PER_SET = 305;
  localparam int SET_COUNT = 6;

  // One sample as it goes onto the bus, in field order of the work item
  typedef struct packed {
    opcode_t     op;
    logic [3:0]  dev;
    logic        on;
    logic [31:0] now;
    logic [10:0] temp;
    logic [13:0] pm;
  } sample_t;

  // One result, same field order as m_tdata from bit 0 upwards (reversed in packing)
  typedef struct packed {
    logic [12:0] aqi;
    logic        held;
    logic        aqi_over;
    logic        pm_over;
    logic        temp_over;
    logic        alarm;
  } report_t;

  // Table row: a sample plus an optional hand-written result
  typedef struct packed {
    sample_t smp;
    logic    typed;
    report_t want;
  } vector_t;

  typedef struct packed {
    logic [10:0] temp;
    logic [13:0] pm;
    logic [12:0] aqi;
    logic [19:0] hold;
    logic [4:0]  act;
  } setting_t;

  // PM2.5 breakpoints (tenths) and the index span each one maps to
  localparam int AQI_PM_LO [7] = '{0, 121, 355, 555, 1505, 2505, 3505};
  localparam int AQI_PM_HI [7] = '{120, 354, 554, 1504, 2504, 3504, 5004};
  localparam int AQI_IX_LO [7] = '{0, 51, 101, 151, 201, 301, 401};
  localparam int AQI_IX_HI [7] = '{50, 100, 150, 200, 300, 400, 500};

  // Directed rows run at the reset thresholds: temp 32.0, PM 35.0, AQI 100.0,
  // holdoff 3000 ms, three devices in use. Report fields: aqi, held, a, p, t, alarm.
  localparam int DIRECTED_N = 24;
  localparam vector_t DIRECTED [DIRECTED_N] = '{
    // holdoff window from the zeroed timestamp, then the exact boundary
    '{'{OPC_SCAN, 4'd0, 1'b1, 32'd0, 11'h670, 14'd0}, 1'b1, '{13'd0, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0}},
    '{'{OPC_SCAN, 4'd0, 1'b1, 32'd3000, 11'd850, 14'd0}, 1'b1,
      '{13'd0, 1'b0, 1'b0, 1'b0, 1'b1, 1'b1}},
    '{'{OPC_SCAN, 4'd0, 1'b1, 32'd5999, 11'd850, 14'd0}, 1'b1,
      '{13'd0, 1'b1, 1'b0, 1'b0, 1'b1, 1'b0}},
    // one tenth below / at the PM limit, interpolated AQI left to the predictor
    '{'{OPC_SCAN, 4'd0, 1'b1, 32'd6000, 11'd319, 14'd349}, 1'b0, '0},
    '{'{OPC_SCAN, 4'd0, 1'b1, 32'd6000, 11'd319, 14'd350}, 1'b0, '0},
    // segment breakpoints on a device outside the active range
    '{'{OPC_SCAN, 4'd15, 1'b1, 32'd9, 11'd0, 14'd120}, 1'b1, '{13'd500, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0}},
    '{'{OPC_SCAN, 4'd15, 1'b1, 32'd9, 11'd0, 14'd121}, 1'b1, '{13'd510, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0}},
    '{'{OPC_SCAN, 4'd15, 1'b1, 32'd9, 11'd0, 14'd354}, 1'b1,
      '{13'd1000, 1'b0, 1'b1, 1'b1, 1'b0, 1'b0}},
    '{'{OPC_SCAN, 4'd15, 1'b1, 32'd9, 11'd0, 14'd555}, 1'b1,
      '{13'd1510, 1'b0, 1'b1, 1'b1, 1'b0, 1'b0}},
    '{'{OPC_SCAN, 4'd15, 1'b1, 32'd9, 11'd0, 14'd1505}, 1'b1,
      '{13'd2010, 1'b0, 1'b1, 1'b1, 1'b0, 1'b0}},
    '{'{OPC_SCAN, 4'd15, 1'b1, 32'd9, 11'd0, 14'd5004}, 1'b1,
      '{13'd5000, 1'b0, 1'b1, 1'b1, 1'b0, 1'b0}},
    // above 500.4 the index saturates
    '{'{OPC_SCAN, 4'd15, 1'b1, 32'd9, 11'd0, 14'd5005}, 1'b1,
      '{13'd5000, 1'b0, 1'b1, 1'b1, 1'b0, 1'b0}},
    '{'{OPC_SCAN, 4'd15, 1'b1, 32'd9, 11'd0, 14'h3fff}, 1'b1,
      '{13'd5000, 1'b0, 1'b1, 1'b1, 1'b0, 1'b0}},
    // temperature field extremes
    '{'{OPC_PERIODIC, 4'd15, 1'b1, 32'd9, 11'h3ff, 14'd0}, 1'b1,
      '{13'd0, 1'b0, 1'b0, 1'b0, 1'b1, 1'b0}},
    '{'{OPC_SCAN, 4'd15, 1'b1, 32'd9, 11'h400, 14'd0}, 1'b1, '{13'd0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0}},
    // device switched off
    '{'{OPC_SCAN, 4'd1, 1'b0, 32'd100, 11'd850, 14'd0}, 1'b1,
      '{13'd0, 1'b0, 1'b0, 1'b0, 1'b1, 1'b0}},
    // periodic reports ignore the holdoff, a scan straight after is held off
    '{'{OPC_PERIODIC, 4'd1, 1'b1, 32'd10, 11'd850, 14'd0}, 1'b1,
      '{13'd0, 1'b0, 1'b0, 1'b0, 1'b1, 1'b1}},
    '{'{OPC_PERIODIC, 4'd1, 1'b1, 32'd11, 11'd850, 14'd0}, 1'b1,
      '{13'd0, 1'b0, 1'b0, 1'b0, 1'b1, 1'b1}},
    '{'{OPC_SCAN, 4'd1, 1'b1, 32'd12, 11'd850, 14'd0}, 1'b1,
      '{13'd0, 1'b1, 1'b0, 1'b0, 1'b1, 1'b0}},
    '{'{OPC_PERIODIC, 4'd2, 1'b1, 32'd5, 11'd0, 14'd0}, 1'b1, '{13'd0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0}},
    // timestamp wrap: event at all-ones, then windows measured across zero
    '{'{OPC_SCAN, 4'd2, 1'b1, 32'hffff_ffff, 11'd850, 14'd0}, 1'b1,
      '{13'd0, 1'b0, 1'b0, 1'b0, 1'b1, 1'b1}},
    '{'{OPC_SCAN, 4'd2, 1'b1, 32'd2998, 11'd850, 14'd0}, 1'b1,
      '{13'd0, 1'b1, 1'b0, 1'b0, 1'b1, 1'b0}},
    '{'{OPC_SCAN, 4'd2, 1'b1, 32'd2999, 11'd850, 14'd0}, 1'b1,
      '{13'd0, 1'b0, 1'b0, 1'b0, 1'b1, 1'b1}},
    // first index past the active count
    '{'{OPC_SCAN, 4'd3, 1'b1, 32'd50000, 11'd850, 14'd0}, 1'b1,
      '{13'd0, 1'b0, 1'b0, 1'b0, 1'b1, 1'b0}}
  };

  // Threshold sets for the random phases; the fourth is drawn at run time
  localparam setting_t THRESHOLD_SETS [SET_COUNT] = '{
    '{11'd320, 14'd350, 13'd1000, 20'd3000, 5'd3},
    '{11'h670, 14'd0, 13'd0, 20'd0, 5'd16},
    '{11'd850, 14'd10000, 13'd5000, 20'd600000, 5'd1},
    '{11'd0, 14'd0, 13'd0, 20'd0, 5'd1},
    '{11'h400, 14'h3fff, 13'h1fff, 20'hfffff, 5'd31},
    '{11'h3ff, 14'd0, 13'h1fff, 20'd1, 5'd0}
  };

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  cfg_wen = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  logic                  s_tvalid = 1'b0;
  logic                  s_tready;
  logic [63:0]           s_tdata = '0;
  logic                  s_tuser = 1'b0;
  logic                  m_tvalid;
  logic                  m_tready = 1'b0;
  logic [23:0]           m_tdata;

  // Predictor copy of the thresholds and per-device event times
  logic [10:0] lim_temp = 11'd320;
  logic [13:0] lim_pm = 14'd350;
  logic [12:0] lim_aqi = 13'd1000;
  logic [19:0] holdoff = 20'd3000;
  logic [4:0]  active_n = 5'd3;
  logic [31:0] last_alarm_ms [16];

  vector_t offered [$];     // driven, not yet taken by the unit
  report_t awaited [$];     // predicted reports, oldest first
  logic [31:0] clock_ms;    // running sensor time for the random phases
  logic steady = 1'b0;      // when set neither side inserts idle cycles
  int stall_left = 0;
  int unsigned cycle_count = 0;
  int mismatches = 0;
  int n_scan = 0, n_periodic = 0, n_alarm = 0, n_held = 0;

  sensor_alarm_with_holdoff_unit #(.DEVICES(16)) dut (
    .clk      (clk),
    .rst      (rst),
    .cfg_wen  (cfg_wen),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),   // [3:0] dev, [4] on, [36:5] now_ms, [47:37] temp, [61:48] pm25
    .s_tuser  (s_tuser),   // [0] opcode
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)    // [0] alarm, [1] temp, [2] pm25, [3] aqi over, [4] held, [17:5] aqi
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // EPA breakpoint interpolation in tenths, floored
  function automatic logic [12:0] pm_to_aqi(input logic [13:0] pm);
    int p;
    p = pm;
    for (int k = 0; k < 7; k++) begin
      if (p >= AQI_PM_LO[k] && p <= AQI_PM_HI[k])
        return 13'(10 * AQI_IX_LO[k] + (10 * (AQI_IX_HI[k] - AQI_IX_LO[k]) * (p - AQI_PM_LO[k]))
                   / (AQI_PM_HI[k] - AQI_PM_LO[k]));
    end
    return 13'd5000;
  endfunction

  // Works out the report for one sample and records the event time if one fires
  function automatic report_t assess_sample(input sample_t s);
    report_t r;
    logic any_over;
    logic [31:0] elapsed;
    r = '0;
    r.aqi = pm_to_aqi(s.pm);
    r.temp_over = $signed(s.temp) >= $signed(lim_temp);
    r.pm_over = s.pm >= lim_pm;
    r.aqi_over = r.aqi >= lim_aqi;
    any_over = r.temp_over | r.pm_over | r.aqi_over;
    if (s.on && {1'b0, s.dev} < active_n) begin
      if (s.op == OPC_SCAN) begin
        elapsed = s.now - last_alarm_ms[s.dev];
        if (elapsed < {12'd0, holdoff}) r.held = 1'b1;
        else r.alarm = any_over;
      end else begin
        r.alarm = any_over;
      end
      if (r.alarm) last_alarm_ms[s.dev] = s.now;
    end
    return r;
  endfunction

  // Random sample, mostly from in-range devices, with a share of times near their holdoff edge
  function automatic sample_t draw_sample();
    sample_t s;
    int r;
    int top;
    top = (active_n == 0 || active_n > 16) ? 15 : int'(active_n) - 1;
    s.dev = ($urandom_range(0, 99) < 85) ? 4'($urandom_range(0, top)) : 4'($urandom_range(0, 15));
    s.on = $urandom_range(0, 99) < 88;
    s.op = ($urandom_range(0, 99) < 70) ? OPC_SCAN : OPC_PERIODIC;
    r = $urandom_range(0, 99);
    if (r < 45) begin
      clock_ms = clock_ms + $urandom_range(0, holdoff / 2 + 3);
      s.now = clock_ms;
    end else if (r < 70) begin
      s.now = last_alarm_ms[s.dev] + holdoff + $urandom_range(0, 4) - 2;
    end else if (r < 90) begin
      clock_ms = clock_ms + $urandom_range(0, 2 * holdoff + 10);
      s.now = clock_ms;
    end else begin
      s.now = $urandom();
    end
    r = $urandom_range(0, 99);
    if (r < 15) s.temp = 11'($urandom_range(0, 2047));
    else if (r < 35) s.temp = 11'(lim_temp + $urandom_range(0, 2) - 1);
    else s.temp = 11'($urandom_range(0, 1250) - 400);
    r = $urandom_range(0, 99);
    if (r < 10) s.pm = 14'($urandom_range(0, 16383));
    else if (r < 30) s.pm = 14'(lim_pm + $urandom_range(0, 2) - 1);
    else if (r < 60) s.pm = 14'($urandom_range(0, 600));
    else s.pm = 14'($urandom_range(0, 10000));
    return s;
  endfunction

  // Writes all five registers on consecutive edges; the unit is idle here
  task automatic load_thresholds(input setting_t t);
    cfg_wen <= 1'b1;
    cfg_index <= CFG_TEMP_LIMIT;
    cfg_data <= 20'(t.temp);
    @(posedge clk);
    cfg_index <= CFG_PM25_LIMIT;
    cfg_data <= 20'(t.pm);
    @(posedge clk);
    cfg_index <= CFG_AQI_LIMIT;
    cfg_data <= 20'(t.aqi);
    @(posedge clk);
    cfg_index <= CFG_HOLDOFF;
    cfg_data <= t.hold;
    @(posedge clk);
    cfg_index <= CFG_ACTIVE;
    cfg_data <= 20'(t.act);
    @(posedge clk);
    cfg_wen <= 1'b0;
    lim_temp = t.temp;
    lim_pm = t.pm;
    lim_aqi = t.aqi;
    holdoff = t.hold;
    active_n = t.act;
  endtask

  // Puts one sample on the slave side and returns at the edge that takes it.
  // tvalid stays high into the next call unless an idle gap is drawn.
  task automatic offer_sample(input vector_t v);
    if (!steady && $urandom_range(0, 99) < 28) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 30)) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= {2'b00, v.smp.pm, v.smp.temp, v.smp.now, v.smp.on, v.smp.dev};
    s_tuser <= v.smp.op;
    offered.push_back(v);
    do @(posedge clk); while (!s_tready);
  endtask

  // Nothing in flight on either side
  task automatic drain();
    while (offered.size() != 0 || awaited.size() != 0) @(posedge clk);
  endtask

  task automatic note_mismatch(input report_t want, input report_t got, input string what);
    mismatches++;
    if (mismatches <= 10)
      $display("mismatch %0d (%s): expected alarm=%b t=%b p=%b a=%b held=%b aqi=%0d, got alarm=%b t=%b p=%b a=%b held=%b aqi=%0d",
               mismatches, what, want.alarm, want.temp_over, want.pm_over, want.aqi_over,
               want.held, want.aqi, got.alarm, got.temp_over, got.pm_over, got.aqi_over,
               got.held, got.aqi);
  endtask

  // Result side back-pressure: about 28% idle in all, single stall cycles plus the odd long stall
  always @(posedge clk) begin
    if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      m_tready <= 1'b0;
    end else if (!steady && $urandom_range(0, 999) < 3) begin
      stall_left <= $urandom_range(20, 40);
      m_tready <= 1'b0;
    end else begin
      m_tready <= steady || ($urandom_range(0, 99) >= 21);
    end
  end

  // Slave-side transaction taken: predict its report now, in acceptance order
  always @(posedge clk) begin : sample_taken
    vector_t v;
    report_t p;
    if (!rst && s_tvalid && s_tready && offered.size() != 0) begin
      v = offered.pop_front();
      p = assess_sample(v.smp);
      awaited.push_back(v.typed ? v.want : p);
      if (v.smp.op == OPC_SCAN) n_scan++;
      else n_periodic++;
    end
  end

  // Master-side transaction: compare with the oldest awaited report
  always @(posedge clk) begin : report_check
    report_t got;
    report_t want;
    if (!rst && m_tvalid && m_tready) begin
      got = report_t'(m_tdata[17:0]);
      n_alarm += got.alarm;
      n_held += got.held;
      if (awaited.size() == 0) begin
        note_mismatch('0, got, "no report outstanding");
      end else begin
        want = awaited.pop_front();
        if (got.alarm !== want.alarm || got.temp_over !== want.temp_over ||
            got.pm_over !== want.pm_over || got.aqi_over !== want.aqi_over ||
            got.held !== want.held || got.aqi !== want.aqi)
          note_mismatch(want, got, "field");
        else if (m_tdata[23:18] !== 6'd0)
          note_mismatch(want, got, "pad bits set");
      end
    end
  end

  // Watchdog: a hang anywhere ends the run as a failure
  initial begin : watchdog
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("FAIL sensor_alarm_with_holdoff_unit");
    $finish;
  end

  initial begin : stimulus
    vector_t v;
    setting_t t;
    foreach (last_alarm_ms[i]) last_alarm_ms[i] = '0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // Directed table at the reset thresholds
    foreach (DIRECTED[i]) offer_sample(DIRECTED[i]);
    s_tvalid <= 1'b0;

    // Random phases, one threshold set each, written only once the unit is empty
    for (int ph = 0; ph < SET_COUNT; ph++) begin
      drain();
      repeat (4) @(posedge clk);
      t = THRESHOLD_SETS[ph];
      if (ph == 3) begin
        t.temp = 11'($urandom_range(0, 1250) - 400);
        t.pm = 14'($urandom_range(0, 10000));
        t.aqi = 13'($urandom_range(0, 5000));
        t.hold = 20'($urandom_range(0, 20000));
        t.act = 5'($urandom_range(1, 16));
      end
      load_thresholds(t);
      // one phase runs flat out on both sides; some start just short of the time wrap
      steady = (ph == 2);
      clock_ms = ($urandom_range(0, 2) == 0) ? 32'hffff_0000 + $urandom_range(0, 65535) : $urandom();
      for (int n = 0; n < SAMPLES_PER_SET; n++) begin
        v.smp = draw_sample();
        v.typed = 1'b0;
        v.want = '0;
        offer_sample(v);
      end
      s_tvalid <= 1'b0;
    end
    steady = 1'b0;

    drain();
    repeat (40) @(posedge clk);   // room for any stray extra result to show up

    $display("Run covered %0d samples (%0d scan, %0d periodic) over reset plus %0d threshold sets",
             n_scan + n_periodic, n_scan, n_periodic, SET_COUNT);
    $display("Alarm events seen: %0d, held off: %0d, mismatches: %0d", n_alarm, n_held, mismatches);
    if (mismatches == 0)
      $display("PASS sensor_alarm_with_holdoff_unit");
    else
      $display("FAIL sensor_alarm_with_holdoff_unit");
    $finish;
  end

endmodule

@@ sim.f @@
src/sae_pkg.sv
src/sae_ram.sv
src/sensor_alarm_with_holdoff_unit.sv
tb/sv/sensor_alarm_with_holdoff_unit_tb.sv
